>>> sv/gde_pkg.sv
// gde_pkg: shared types, constants and helpers of the grid distance block
// depends on nothing
`default_nettype none
package gde_pkg;
  localparam int GridMax  = 64;
  localparam int RowW     = 6;
  localparam int DistW    = 7;
  localparam int AddrW    = 2 * RowW;
  localparam logic [DistW-1:0] GridReset = 7'd64;
  localparam logic [DistW-1:0] GridLimit = 7'd64;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_READ  = 1'b1;

  typedef enum logic [1:0] {
    CMD_WRITE,
    CMD_READ_ZERO,
    CMD_READ_CELL
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e         kind;
    logic [RowW-1:0]   row;
    logic [RowW-1:0]   column;
    logic [GridMax-1:0] row_bits;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } q_head_t;

  // grid size in use: zero acts as one, large values saturate
  function automatic logic [DistW-1:0] used_size(input logic [DistW-1:0] g);
    logic [DistW-1:0] n;
    n = g;
    if (g == '0) n = 7'd1;
    else if (g > GridLimit) n = GridLimit;
    return n;
  endfunction

  function automatic logic [DistW-1:0] dmin(input logic [DistW-1:0] a,
                                            input logic [DistW-1:0] b);
    return (a < b) ? a : b;
  endfunction
endpackage
`default_nettype wire

>>> sv/gde_if.sv
// gde_if: valid/ready channel interfaces for commands and distances
// depends on gde_pkg
`default_nettype none
interface gde_in_if import gde_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               operation;
  logic [RowW-1:0]    row;
  logic [RowW-1:0]    column;
  logic [GridMax-1:0] row_bits;
  modport source (output valid, operation, row, column, row_bits, input ready);
  modport sink (input valid, operation, row, column, row_bits, output ready);
endinterface

interface gde_out_if import gde_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [DistW-1:0] distance;
  modport source (output valid, distance, input ready);
  modport sink (input valid, distance, output ready);
endinterface
`default_nettype wire

>>> sv/gde_front.sv
// gde_front: accepts command beats, classifies them and queues them
// depends on gde_pkg, gde_if
`default_nettype none
module gde_front import gde_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic [DistW-1:0] size_i,
  gde_in_if.sink                in_i,
  output q_head_t               head_o,
  input  wire logic             pop_i
);
  cmd_t       entry_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;
  cmd_t       cls;
  logic       push;

  always_comb begin
    cls.row      = in_i.row;
    cls.column   = in_i.column;
    cls.row_bits = in_i.row_bits;
    if (in_i.operation == OP_WRITE) begin
      cls.kind = CMD_WRITE;
    end else if ({1'b0, in_i.row} >= size_i || {1'b0, in_i.column} >= size_i) begin
      cls.kind = CMD_READ_ZERO;
    end else begin
      cls.kind = CMD_READ_CELL;
    end
  end

  assign in_i.ready   = (count_q != 2'd2);
  assign push         = in_i.valid && in_i.ready;
  assign head_o.valid = (count_q != 2'd0);
  assign head_o.cmd   = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) entry_q[wr_ptr_q] <= cls;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop_i) rd_ptr_q <= ~rd_ptr_q;
      count_q <= count_q + {1'b0, push} - {1'b0, pop_i};
    end
  end
endmodule
`default_nettype wire

>>> sv/gde_back.sv
// gde_back: mask and distance memories, raster recompute engine, result register
// depends on gde_pkg, gde_if
`default_nettype none
module gde_back import gde_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic [DistW-1:0] size_i,
  input  wire logic             cfg_we_i,
  input  q_head_t               head_i,
  output logic                  pop_o,
  gde_out_if.source             out_o
);
  typedef enum logic [2:0] {
    ST_IDLE, ST_RD, ST_F_RD, ST_F_WR, ST_B_RD, ST_B_WR
  } state_e;

  state_e           state_q, state_d;
  logic [RowW-1:0]  r_q, r_d, c_q, c_d;
  logic [DistW-1:0] nb_q, nb_d;
  logic             stale_q, stale_d;
  logic             out_v_q, out_v_d;
  logic [DistW-1:0] out_q, out_d;

  logic [GridMax-1:0] mask_mem [GridMax];
  logic [GridMax-1:0] row_vld_q;
  logic [DistW-1:0]   dist_mem [GridMax*GridMax];
  logic [GridMax-1:0] mrow_q;
  logic [DistW-1:0]   rda_q, rdb_q;
  logic [AddrW-1:0]   rd_a, rd_b, wr_addr;
  logic [DistW-1:0]   wr_data;
  logic               wr_en, mask_we, slot_free;
  logic [DistW-1:0]   nm1, near, val;
  logic               r_last, c_last;

  assign nm1       = size_i - 7'd1;
  assign r_last    = ({1'b0, r_q} == nm1);
  assign c_last    = ({1'b0, c_q} == nm1);
  assign slot_free = !out_v_q || out_o.ready;

  always_comb begin
    state_d = state_q;
    r_d     = r_q;
    c_d     = c_q;
    nb_d    = nb_q;
    stale_d = stale_q || cfg_we_i;
    out_v_d = out_v_q && !out_o.ready;
    out_d   = out_q;
    pop_o   = 1'b0;
    mask_we = 1'b0;
    wr_en   = 1'b0;
    wr_addr = {r_q, c_q};
    wr_data = '0;
    rd_a    = {r_q, c_q};
    rd_b    = {r_q, c_q};
    near    = '0;
    val     = '0;
    case (state_q)
      ST_IDLE: begin
        if (head_i.valid) begin
          case (head_i.cmd.kind)
            CMD_WRITE: begin
              mask_we = 1'b1;
              stale_d = 1'b1;
              pop_o   = 1'b1;
            end
            CMD_READ_ZERO: begin
              if (slot_free) begin
                out_v_d = 1'b1;
                out_d   = '0;
                pop_o   = 1'b1;
              end
            end
            CMD_READ_CELL: begin
              if (stale_q) begin
                r_d     = '0;
                c_d     = '0;
                state_d = ST_F_RD;
              end else if (slot_free) begin
                rd_a    = {head_i.cmd.row, head_i.cmd.column};
                pop_o   = 1'b1;
                state_d = ST_RD;
              end
            end
            default: pop_o = 1'b1;
          endcase
        end
      end
      ST_RD: begin
        out_v_d = 1'b1;
        out_d   = rda_q;
        state_d = ST_IDLE;
      end
      ST_F_RD: begin
        rd_a    = {r_q - 6'd1, c_q};
        state_d = ST_F_WR;
      end
      ST_F_WR: begin
        // forward pass: nearest via up or left, outside counts as zero
        near    = dmin((r_q == '0) ? '0 : rda_q, (c_q == '0) ? '0 : nb_q);
        val     = mrow_q[c_q] ? near + 7'd1 : '0;
        wr_en   = 1'b1;
        wr_data = val;
        nb_d    = val;
        state_d = ST_F_RD;
        if (c_last) begin
          c_d = '0;
          r_d = r_q + 6'd1;
          if (r_last) begin
            r_d     = nm1[RowW-1:0];
            c_d     = nm1[RowW-1:0];
            state_d = ST_B_RD;
          end
        end else begin
          c_d = c_q + 6'd1;
        end
      end
      ST_B_RD: begin
        rd_a    = {r_q + 6'd1, c_q};
        state_d = ST_B_WR;
      end
      ST_B_WR: begin
        // backward pass: fold in down and right neighbors
        near    = dmin(r_last ? '0 : rda_q, c_last ? '0 : nb_q);
        val     = dmin(rdb_q, near + 7'd1);
        wr_en   = 1'b1;
        wr_data = val;
        nb_d    = val;
        state_d = ST_B_RD;
        if (c_q == '0) begin
          c_d = nm1[RowW-1:0];
          r_d = r_q - 6'd1;
          if (r_q == '0) begin
            stale_d = 1'b0;
            state_d = ST_IDLE;
          end
        end else begin
          c_d = c_q - 6'd1;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mask_we) mask_mem[head_i.cmd.row] <= head_i.cmd.row_bits;
    mrow_q <= row_vld_q[r_q] ? mask_mem[r_q] : '0;
    if (wr_en) dist_mem[wr_addr] <= wr_data;
    rda_q <= dist_mem[rd_a];
    rdb_q <= dist_mem[rd_b];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      r_q       <= '0;
      c_q       <= '0;
      nb_q      <= '0;
      stale_q   <= 1'b1;
      out_v_q   <= 1'b0;
      out_q     <= '0;
      row_vld_q <= '0;
    end else begin
      state_q <= state_d;
      r_q     <= r_d;
      c_q     <= c_d;
      nb_q    <= nb_d;
      stale_q <= stale_d;
      out_v_q <= out_v_d;
      out_q   <= out_d;
      if (mask_we) row_vld_q[head_i.cmd.row] <= 1'b1;
    end
  end

  // rows never written since reset read as all outside
  assign out_o.valid    = out_v_q;
  assign out_o.distance = out_q;
endmodule
`default_nettype wire

>>> sv/grid_distance_to_edge.sv
// grid_distance_to_edge: top level, grid size register, front queue and back engine
// depends on gde_pkg, gde_if, gde_front, gde_back
`default_nettype none
// Write mask rows and read city-block distances to the nearest outside cell.
// A row write retires once it is at the head of the two-beat queue and the
// engine is idle. A read of a current grid passes through the queue, the
// registered distance memory read and the result register; a read outside
// the grid goes from the queue to the result register and presents 0. The
// first in-grid read after any row or grid_size write first runs a forward and
// a backward raster pass over the distance memory, with a read state and a
// write state per cell and pass, the registered read preceding each cell write.
module grid_distance_to_edge import gde_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_we_i,
  input  wire logic [DistW-1:0] cfg_data_i,
  gde_in_if.sink                in_i,
  gde_out_if.source             out_o
);
  logic [DistW-1:0] grid_q, size;
  q_head_t          head;
  logic             pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) grid_q <= GridReset;
    else if (cfg_we_i) grid_q <= cfg_data_i;
  end

  assign size = used_size(grid_q);

  gde_front u_front (
    .clk_i, .rst_ni, .size_i(size), .in_i, .head_o(head), .pop_i(pop)
  );

  gde_back u_back (
    .clk_i, .rst_ni, .size_i(size), .cfg_we_i, .head_i(head), .pop_o(pop), .out_o
  );
endmodule
`default_nettype wire

>>> sv/gde_checker.sv
// gde_checker: port-level assertions for grid_distance_to_edge, bound to the top
// depends on gde_pkg
`default_nettype none
module gde_checker import gde_pkg::*; (
  input wire logic             clk_i,
  input wire logic             rst_ni,
  input wire logic             out_valid,
  input wire logic             out_ready,
  input wire logic [DistW-1:0] out_distance
);
  a_reset_quiet: assert property (@(posedge clk_i) !rst_ni |-> !out_valid)
    else $error("result beat during reset");
  a_dist_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> out_distance <= GridLimit)
    else $error("distance beyond grid limit");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped");
  a_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> $stable(out_distance))
    else $error("stalled distance changed");
endmodule

bind grid_distance_to_edge gde_checker u_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .out_valid(out_o.valid),
  .out_ready(out_o.ready), .out_distance(out_o.distance)
);
`default_nettype wire

>>> tb/tb_top.sv
// tb_top: self-checking bench for grid_distance_to_edge, random mask writes and reads
// depends on gde_pkg, gde_if and the rtl top level
`timescale 1ns / 1ps
module tb_top import gde_pkg::*;;
  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [DistW-1:0] cfg_data_i = '0;

  gde_in_if in_bus ();
  gde_out_if out_bus ();

  grid_distance_to_edge dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_data_i(cfg_data_i),
    .in_i(in_bus.sink), .out_o(out_bus.source)
  );

  always #5 clk_i = ~clk_i;

  typedef struct {
    logic            op;
    logic [RowW-1:0] row;
    logic [RowW-1:0] column;
    logic [63:0]     bits;
  } req_t;

  req_t pending_reqs[$];
  logic [DistW-1:0] expected_dist[$];

  // local copy of block state
  logic [63:0] mask_mem[GridMax];
  logic [DistW-1:0] dist_mem[GridMax][GridMax];
  logic [DistW-1:0] size_reg;
  bit stale;
  bit in_taken = 1'b0;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int mismatches = 0;
  int cycles = 0;
  int reads_issued = 0;

  function automatic int eff_size();
    int n;
    n = size_reg;
    if (n < 1) n = 1;
    if (n > GridMax) n = GridMax;
    return n;
  endfunction

  // breadth-first distances from outside cells and the grid border
  function automatic void flood_distances();
    int n, d, head, tail, r, c, k, nr, nc, idx;
    int work[GridMax*GridMax];
    int fifo[GridMax*GridMax];
    int dr[4] = '{1, 0, -1, 0};
    int dc[4] = '{0, 1, 0, -1};
    n = eff_size();
    head = 0;
    tail = 0;
    for (r = 0; r < n; r++)
      for (c = 0; c < n; c++) begin
        idx = r * GridMax + c;
        if (!mask_mem[r][c]) begin
          work[idx] = 0;
          fifo[tail++] = idx;
        end else begin
          work[idx] = -1;
        end
      end
    for (r = 0; r < n; r++)
      for (c = 0; c < n; c++) begin
        idx = r * GridMax + c;
        if (work[idx] < 0 && (r == 0 || c == 0 || r == n - 1 || c == n - 1)) begin
          work[idx] = 1;
          fifo[tail++] = idx;
        end
      end
    while (head < tail) begin
      idx = fifo[head++];
      for (k = 0; k < 4; k++) begin
        nr = idx / GridMax + dr[k];
        nc = idx % GridMax + dc[k];
        if (nr < 0 || nc < 0 || nr >= n || nc >= n) continue;
        if (work[nr * GridMax + nc] < 0) begin
          work[nr * GridMax + nc] = work[idx] + 1;
          fifo[tail++] = nr * GridMax + nc;
        end
      end
    end
    for (r = 0; r < n; r++)
      for (c = 0; c < n; c++) begin
        d = work[r * GridMax + c];
        if (d < 0) d = 0;
        if (d > 127) d = 127;
        dist_mem[r][c] = d[DistW-1:0];
      end
    stale = 0;
  endfunction

  function automatic void predict_distance(req_t q);
    int n;
    if (q.op == OP_WRITE) begin
      mask_mem[q.row] = q.bits;
      stale = 1;
      return;
    end
    n = eff_size();
    if (q.row >= n || q.column >= n) begin
      expected_dist = {expected_dist, DistW'(0)};
      return;
    end
    if (stale) flood_distances();
    expected_dist = {expected_dist, dist_mem[q.row][q.column]};
  endfunction

  // driver
  always @(negedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_bus.valid <= 1'b0;
      in_bus.operation <= OP_WRITE;
      in_bus.row <= '0;
      in_bus.column <= '0;
      in_bus.row_bits <= '0;
    end else begin
      if (!in_bus.valid || in_taken) begin
        if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_bus.valid <= 1'b1;
          in_bus.operation <= pending_reqs[0].op;
          in_bus.row <= pending_reqs[0].row;
          in_bus.column <= pending_reqs[0].column;
          in_bus.row_bits <= pending_reqs[0].bits;
        end else begin
          in_bus.valid <= 1'b0;
        end
      end
      out_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // accepted command beats feed the predictor
  always @(posedge clk_i) begin
    in_taken <= rst_ni && in_bus.valid && in_bus.ready;
    if (rst_ni && in_bus.valid && in_bus.ready) begin
      predict_distance(pending_reqs.pop_front());
    end
  end

  // monitor
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (rst_ni && out_bus.valid && out_bus.ready) begin
      if (expected_dist.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected distance beat %0d", out_bus.distance);
      end else begin
        if (out_bus.distance !== expected_dist[0]) begin
          mismatches++;
          if (mismatches <= 10)
            $display("distance mismatch: expected %0d actual %0d",
                     expected_dist[0], out_bus.distance);
        end
        void'(expected_dist.pop_front());
      end
    end
  end

  always @(posedge clk_i) begin
    if (cycles > 10000000) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial out_bus.ready = 1'b0;

  task automatic add_req(logic op, int r, int c, logic [63:0] b);
    req_t q;
    q.op = op;
    q.row = r[RowW-1:0];
    q.column = c[RowW-1:0];
    q.bits = b;
    pending_reqs = {pending_reqs, q};
    if (op == OP_READ) reads_issued++;
  endtask

  function automatic logic [63:0] rand_bits64();
    return {$urandom(), $urandom()};
  endfunction

  task automatic drain();
    while (pending_reqs.size() > 0 || expected_dist.size() > 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic set_size(int s);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_data_i <= s[DistW-1:0];
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    size_reg = s[DistW-1:0];
    stale = 1;
  endtask

  // a mask that is mostly inside so that distances grow past one
  function automatic logic [63:0] blob_bits();
    logic [63:0] b;
    b = ~64'd0;
    if ($urandom_range(3) == 0) b = b & rand_bits64() | rand_bits64();
    else if ($urandom_range(2) == 0) b[$urandom_range(63)] = 1'b0;
    return b;
  endfunction

  task automatic random_phase(int items, int sz);
    int i, n;
    n = sz < 1 ? 1 : (sz > GridMax ? GridMax : sz);
    for (i = 0; i < items; i++) begin
      if ($urandom_range(9) < 3) begin
        add_req(OP_WRITE, $urandom_range(n - 1), $urandom_range(63),
                $urandom_range(1) ? blob_bits() : rand_bits64());
      end else if ($urandom_range(9) == 0) begin
        add_req(OP_READ, $urandom_range(63), $urandom_range(63), rand_bits64());
      end else begin
        add_req(OP_READ, $urandom_range(n - 1), $urandom_range(n - 1), rand_bits64());
      end
    end
  endtask

  int ph;
  int sizes[6] = '{64, 8, 1, 0, 127, 5};

  initial begin
    for (int r = 0; r < GridMax; r++) mask_mem[r] = '0;
    size_reg = GridReset;
    stale = 1;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: full mask, border cells, center, out of grid reads
    for (int r = 0; r < GridMax; r++) add_req(OP_WRITE, r, 0, ~64'd0);
    add_req(OP_READ, 0, 0, '0);
    add_req(OP_READ, 31, 31, ~64'd0);
    add_req(OP_READ, 63, 63, '0);
    add_req(OP_READ, 32, 0, '0);
    add_req(OP_WRITE, 32, 63, 64'hFFFF_FFFE_FFFF_FFFF);
    add_req(OP_READ, 32, 32, '0);
    add_req(OP_READ, 32, 31, '0);
    add_req(OP_READ, 20, 33, '0);
    drain();
    set_size(3);
    add_req(OP_READ, 1, 1, '0);
    add_req(OP_READ, 3, 0, '0);
    add_req(OP_READ, 0, 63, '0);
    add_req(OP_WRITE, 50, 0, '0);
    add_req(OP_READ, 1, 1, '0);
    drain();

    for (ph = 0; ph < 6; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0; recv_stall_pct = 0; end
        1: begin send_idle_pct = 50; recv_stall_pct = 0; end
        2: begin send_idle_pct = 0; recv_stall_pct = 50; end
        default: begin send_idle_pct = 21; recv_stall_pct = 21; end
      endcase
      set_size(sizes[ph]);
      random_phase(ph == 0 ? 60 : 128, sizes[ph]);
      drain();
    end

    if (mismatches == 0 && expected_dist.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
